@@ rtl/tsrr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrr_pkg
// Shared types and constants for the task slot round-robin scheduler.
// ----------------------------------------------------------------------------
package tsrr_pkg;

    localparam int NUM_SLOTS_DEF  = 32;
    localparam int EVENT_BITS_DEF = 16;

    // bit positions inside one slot table row
    localparam int ROW_USED   = 0;
    localparam int ROW_WAIT   = 1;
    localparam int ROW_EXIT   = 2;
    localparam int ROW_EV_LSB = 3;

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_YIELD    = 3'd1,
        OP_FINISH   = 3'd2,
        OP_SUSPEND  = 3'd3,
        OP_WAKE     = 3'd4,
        OP_REQ_EXIT = 3'd5,
        OP_KILL     = 3'd6,
        OP_QUERY    = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NO_FREE = 3'd1,
        ST_NONE    = 3'd2,
        ST_UNUSED  = 3'd3,
        ST_MASTER  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_ACC,
        S_SCAN,
        S_END
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [4:0]  task_id;
        logic [15:0] event_code;
    } t_in_item;

    typedef struct packed {
        logic [4:0] slot;
        t_status    status;
        logic       in_use;
        logic       exit_requested;
        logic [5:0] live_count;
        logic       master_running;
        logic       last;
    } t_out_item;

endpackage

@@ rtl/tsrr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsrr_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/tsrr_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrr_out_reg
// Result register that decouples the sequencer from the output consumer.
// ----------------------------------------------------------------------------
module tsrr_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tsrr_pkg::t_out_item i_item,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_ready,
    output tsrr_pkg::t_out_item o_item
);
    import tsrr_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_item <= i_item;
        end
    end

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ rtl/task_slot_round_robin_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_slot_round_robin_scheduler
// Round-robin task slot scheduler with event wait, slot table held in RAM.
// ----------------------------------------------------------------------------
// The slot table (in-use, waiting, exit-requested and awaited event per slot)
// lives in one RAM with a registered read; a flip-flop valid bit per
// row makes never-written rows read as free, so no clearing pass follows reset.
// One operation is handled at a time. Suspend, request exit, kill, query,
// finish and a yield by a running task touch one row: the row is read in
// S_ISSUE, and the result is loaded into the output register from S_ACC once
// the output register is free. Add, a yield from master and wake scan the
// table one slot per cycle through the single RAM read port while the output
// is not stalled (add and yield stop at the first hit). Wake gives one result
// per woken slot in ascending slot order, the final one marked by last; a
// stalled output pauses the scan. A new transaction is taken as soon as the
// sequencer is idle, even while the previous result still waits in the output register.
module task_slot_round_robin_scheduler #(
    parameter int NUM_SLOTS  = tsrr_pkg::NUM_SLOTS_DEF,
    parameter int EVENT_BITS = tsrr_pkg::EVENT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tsrr_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tsrr_pkg::t_out_item o_out_data
);
    import tsrr_pkg::*;

    localparam int SW    = $clog2(NUM_SLOTS);
    localparam int CW    = $clog2(NUM_SLOTS + 1);
    localparam int ROW_W = EVENT_BITS + ROW_EV_LSB;

    // sequencer state
    t_state          r_state, n_state;
    t_in_item        r_in, n_in;
    logic [SW-1:0]   r_tgt, n_tgt;
    logic            r_tgt_ok, n_tgt_ok;
    // scan bookkeeping: next address, reads issued, read in flight
    logic [SW-1:0]   r_ptr, n_ptr;
    logic [CW-1:0]   r_iss, n_iss;
    logic            r_pend, n_pend;
    logic [SW-1:0]   r_eidx, n_eidx;
    // scheduler registers
    logic [SW-1:0]   r_free_ptr, n_free_ptr;
    logic [SW-1:0]   r_last_srv, n_last_srv;
    logic [SW-1:0]   r_cur, n_cur;
    logic            r_cur_valid, n_cur_valid;
    logic [CW-1:0]   r_count, n_count;
    // wake result held back until we know whether it is the final one
    logic            r_hold_valid, n_hold_valid;
    t_out_item       r_hold, n_hold;

    // row valid bits, one per table row
    logic [NUM_SLOTS-1:0] r_row_ok;
    logic                 r_rd_ok;

    // ram ports
    logic                wr_en;
    logic [SW-1:0]       wr_addr;
    logic [ROW_W-1:0]    wr_data;
    logic [SW-1:0]       rd_addr;
    logic [ROW_W-1:0]    rd_data;

    // decoded read row
    logic                  rd_used, rd_wait, rd_exit;
    logic [EVENT_BITS-1:0] rd_ev;
    logic [EVENT_BITS-1:0] in_ev;
    logic                  in_id_ok;
    logic                  scan_hit, hit_v, need_out, stall;

    // output side
    logic      push;
    t_out_item push_item;
    logic      out_free;

    function automatic logic [SW-1:0] slot_up(input logic [SW-1:0] p);
        slot_up = (p == SW'(NUM_SLOTS - 1)) ? '0 : SW'(p + 1'b1);
    endfunction

    function automatic logic [SW-1:0] slot_dn(input logic [SW-1:0] p);
        slot_dn = (p == '0) ? SW'(NUM_SLOTS - 1) : SW'(p - 1'b1);
    endfunction

    tsrr_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    tsrr_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_data)
    );

    // a row that was never written reads as a free slot
    assign rd_used  = r_rd_ok & rd_data[ROW_USED];
    assign rd_wait  = r_rd_ok & rd_data[ROW_WAIT];
    assign rd_exit  = r_rd_ok & rd_data[ROW_EXIT];
    assign rd_ev    = rd_data[ROW_EV_LSB +: EVENT_BITS];
    assign in_ev    = EVENT_BITS'(r_in.event_code);
    assign in_id_ok = ({27'd0, i_in_data.task_id} < 32'(NUM_SLOTS));

    assign o_in_ready = (r_state == S_IDLE);

    // scan hit per operation
    always_comb begin
        case (r_in.op)
            OP_ADD:   scan_hit = !rd_used;
            OP_YIELD: scan_hit = rd_used && !rd_wait;
            OP_WAKE:  scan_hit = rd_used && rd_wait && (rd_ev == in_ev);
            default:  scan_hit = 1'b0;
        endcase
    end

    assign hit_v    = r_pend && scan_hit;
    // a wake hit only needs the output when an earlier hit is held
    assign need_out = (r_in.op != OP_WAKE) || r_hold_valid;
    assign stall    = (r_state == S_SCAN) && hit_v && need_out && !out_free;

    always_comb begin
        n_state      = r_state;
        n_in         = r_in;
        n_tgt        = r_tgt;
        n_tgt_ok     = r_tgt_ok;
        n_ptr        = r_ptr;
        n_iss        = r_iss;
        n_pend       = r_pend;
        n_eidx       = r_eidx;
        n_free_ptr   = r_free_ptr;
        n_last_srv   = r_last_srv;
        n_cur        = r_cur;
        n_cur_valid  = r_cur_valid;
        n_count      = r_count;
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        rd_addr      = r_tgt;
        wr_en        = 1'b0;
        wr_addr      = r_tgt;
        wr_data      = {rd_ev, rd_exit, rd_wait, rd_used};
        push         = 1'b0;
        push_item    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in         = i_in_data;
                    n_hold_valid = 1'b0;
                    n_iss        = '0;
                    n_pend       = 1'b0;
                    n_tgt        = in_id_ok ? SW'(i_in_data.task_id) : '0;
                    n_tgt_ok     = in_id_ok;
                    n_state      = S_ISSUE;
                    case (i_in_data.op)
                        OP_ADD: begin
                            n_ptr   = r_free_ptr;
                            n_state = S_SCAN;
                        end
                        OP_YIELD: begin
                            if (r_cur_valid) begin
                                n_tgt    = r_cur;
                                n_tgt_ok = 1'b1;
                            end else begin
                                n_ptr   = slot_up(r_last_srv);
                                n_state = S_SCAN;
                            end
                        end
                        OP_FINISH: begin
                            n_tgt    = r_cur;
                            n_tgt_ok = r_cur_valid;
                        end
                        OP_WAKE: begin
                            n_ptr   = '0;
                            n_state = S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_ISSUE: begin
                n_state = S_ACC;
            end

            S_ACC: begin
                // row of the addressed slot is on the read port
                if (out_free) begin
                    push                     = 1'b1;
                    n_state                  = S_IDLE;
                    push_item.slot           = r_tgt_ok ? 5'(r_tgt) : '0;
                    push_item.in_use         = r_tgt_ok & rd_used;
                    push_item.exit_requested = r_tgt_ok & rd_exit;
                    push_item.status         = (r_tgt_ok && rd_used) ? ST_OK : ST_UNUSED;
                    push_item.last           = 1'b1;
                    case (r_in.op)
                        OP_YIELD: begin
                            push_item.status = ST_MASTER;
                            n_cur_valid      = 1'b0;
                        end
                        OP_FINISH: begin
                            if (r_tgt_ok) begin
                                push_item.status = ST_OK;
                                push_item.in_use = 1'b0;
                                n_cur_valid      = 1'b0;
                                if (rd_used) begin
                                    wr_en             = 1'b1;
                                    wr_data[ROW_USED] = 1'b0;
                                    n_count           = CW'(r_count - 1'b1);
                                end
                            end
                        end
                        OP_SUSPEND: begin
                            // written even for an unused slot, add clears it later
                            if (r_tgt_ok) begin
                                wr_en                               = 1'b1;
                                wr_data[ROW_WAIT]                   = 1'b1;
                                wr_data[ROW_EV_LSB +: EVENT_BITS]   = in_ev;
                            end
                        end
                        OP_REQ_EXIT: begin
                            if (r_tgt_ok) begin
                                wr_en                    = 1'b1;
                                wr_data[ROW_EXIT]        = 1'b1;
                                push_item.exit_requested = 1'b1;
                            end
                        end
                        OP_KILL: begin
                            if (r_tgt_ok && rd_used) begin
                                wr_en             = 1'b1;
                                wr_data[ROW_USED] = 1'b0;
                                n_count           = CW'(r_count - 1'b1);
                                push_item.in_use  = 1'b0;
                                if (r_cur_valid && (r_cur == r_tgt)) begin
                                    n_cur_valid = 1'b0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // on a stall the same row is read again so its data stays put
                rd_addr = stall ? r_eidx : r_ptr;
                wr_addr = r_eidx;
                if (!stall) begin
                    if (hit_v) begin
                        case (r_in.op)
                            OP_ADD: begin
                                wr_en             = 1'b1;
                                wr_data[ROW_USED] = 1'b1;
                                wr_data[ROW_WAIT] = 1'b0;
                                wr_data[ROW_EXIT] = 1'b0;
                                n_free_ptr        = slot_dn(r_eidx);
                                n_cur             = r_eidx;
                                n_cur_valid       = 1'b1;
                                n_count           = CW'(r_count + 1'b1);
                                push              = 1'b1;
                                push_item.slot    = 5'(r_eidx);
                                push_item.status  = ST_OK;
                                push_item.in_use  = 1'b1;
                                push_item.last    = 1'b1;
                                n_state           = S_IDLE;
                            end
                            OP_YIELD: begin
                                n_last_srv               = r_eidx;
                                n_cur                    = r_eidx;
                                n_cur_valid              = 1'b1;
                                push                     = 1'b1;
                                push_item.slot           = 5'(r_eidx);
                                push_item.status         = ST_OK;
                                push_item.in_use         = 1'b1;
                                push_item.exit_requested = rd_exit;
                                push_item.last           = 1'b1;
                                n_state                  = S_IDLE;
                            end
                            OP_WAKE: begin
                                wr_en             = 1'b1;
                                wr_data[ROW_WAIT] = 1'b0;
                                if (r_hold_valid) begin
                                    push      = 1'b1;
                                    push_item = r_hold;
                                end
                                n_hold_valid          = 1'b1;
                                n_hold                = '0;
                                n_hold.slot           = 5'(r_eidx);
                                n_hold.status         = ST_OK;
                                n_hold.in_use         = 1'b1;
                                n_hold.exit_requested = rd_exit;
                            end
                            default: begin
                            end
                        endcase
                    end
                    if (!(hit_v && (r_in.op != OP_WAKE))) begin
                        if (r_iss != CW'(NUM_SLOTS)) begin
                            n_pend = 1'b1;
                            n_eidx = r_ptr;
                            n_ptr  = (r_in.op == OP_ADD) ? slot_dn(r_ptr) : slot_up(r_ptr);
                            n_iss  = CW'(r_iss + 1'b1);
                        end else begin
                            n_pend = 1'b0;
                            if (!r_pend) begin
                                n_state = S_END;
                            end
                        end
                    end
                end
            end

            S_END: begin
                // flush the held wake result or report an empty scan
                if (out_free) begin
                    push         = 1'b1;
                    n_state      = S_IDLE;
                    n_hold_valid = 1'b0;
                    if (r_hold_valid) begin
                        push_item = r_hold;
                    end else begin
                        push_item.status = (r_in.op == OP_ADD) ? ST_NO_FREE : ST_NONE;
                    end
                    push_item.last = 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        push_item.live_count     = 6'(n_count);
        push_item.master_running = !n_cur_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tgt        <= '0;
            r_tgt_ok     <= 1'b0;
            r_ptr        <= '0;
            r_iss        <= '0;
            r_pend       <= 1'b0;
            r_eidx       <= '0;
            r_free_ptr   <= '0;
            r_last_srv   <= SW'(NUM_SLOTS - 1);
            r_cur        <= '0;
            r_cur_valid  <= 1'b0;
            r_count      <= '0;
            r_hold_valid <= 1'b0;
            r_row_ok     <= '0;
            r_rd_ok      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_tgt        <= n_tgt;
            r_tgt_ok     <= n_tgt_ok;
            r_ptr        <= n_ptr;
            r_iss        <= n_iss;
            r_pend       <= n_pend;
            r_eidx       <= n_eidx;
            r_free_ptr   <= n_free_ptr;
            r_last_srv   <= n_last_srv;
            r_cur        <= n_cur;
            r_cur_valid  <= n_cur_valid;
            r_count      <= n_count;
            r_hold_valid <= n_hold_valid;
            r_rd_ok      <= r_row_ok[rd_addr];
            if (wr_en) begin
                r_row_ok[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_hold <= n_hold;
    end

    // checks
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> out_free)
        else $error("result pushed into a full output register");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_valid)
        else $error("wake result left behind after the operation ended");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(NUM_SLOTS))
        else $error("live count above table size");

    a_cur_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> r_row_ok[r_cur])
        else $error("current task points at a row never written");

    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second transaction taken while busy");

endmodule

@@ tb/task_slot_round_robin_scheduler_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_slot_round_robin_scheduler_tb
// Self-checking bench for the round-robin task slot scheduler. Each accepted
// request transaction is run through an in-bench copy of the slot table that
// predicts every reply; replies are checked field by field in order. Stimulus
// is a short directed walk through the corner cases, then random traffic in
// fill, mixed and drain phases with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module task_slot_round_robin_scheduler_tb;

    import tsrr_pkg::*;

    localparam int NSLOT    = NUM_SLOTS_DEF;
    localparam int SETTLE   = NSLOT + 8;
    localparam int N_FILL   = 60;
    localparam int N_MIX    = 120;
    localparam int N_DRAIN  = 80;
    localparam int N_CALM   = 40;
    localparam int MAX_SHOW = 10;

    // random traffic phases
    typedef enum int {
        PH_FILL,
        PH_MIX,
        PH_DRAIN
    } t_phase;

    // ------------------------------------------------------------------------
    // slot table predictor and reply queue
    // ------------------------------------------------------------------------
    class sched_scoreboard;
        bit          used[NSLOT];
        bit          waiting[NSLOT];
        bit          exit_flag[NSLOT];
        logic [15:0] awaited[NSLOT];
        logic [4:0]  free_ptr;
        logic [4:0]  rr_last;
        logic [4:0]  cur_slot;
        bit          cur_valid;
        logic [5:0]  live;
        t_out_item   due_replies[$];
        int          mismatches;

        function new();
            for (int s = 0; s < NSLOT; s++) begin
                used[s]      = 1'b0;
                waiting[s]   = 1'b0;
                exit_flag[s] = 1'b0;
                awaited[s]   = '0;
            end
            free_ptr   = '0;
            rr_last    = 5'(NSLOT - 1);
            cur_slot   = '0;
            cur_valid  = 1'b0;
            live       = '0;
            mismatches = 0;
        endfunction

        // reply as seen after the state update of the operation
        function t_out_item reply(logic [4:0] s, t_status st, bit has_slot, bit fin);
            t_out_item r;
            r.slot           = has_slot ? s : '0;
            r.status         = st;
            r.in_use         = has_slot ? used[s] : 1'b0;
            r.exit_requested = has_slot ? exit_flag[s] : 1'b0;
            r.live_count     = live;
            r.master_running = !cur_valid;
            r.last           = fin;
            return r;
        endfunction

        function void note_request(t_in_item it);
            logic [4:0] p;
            logic [4:0] id;
            bit         hit;
            int         woken;
            id    = it.task_id;
            hit   = 1'b0;
            woken = 0;
            p     = '0;
            case (it.op)
                OP_ADD: begin
                    p = free_ptr;
                    for (int k = 0; k < NSLOT; k++) begin
                        if (!hit) begin
                            if (!used[p]) begin
                                hit          = 1'b1;
                                used[p]      = 1'b1;
                                waiting[p]   = 1'b0;
                                exit_flag[p] = 1'b0;
                                free_ptr     = (p == 0) ? 5'(NSLOT - 1) : p - 1'b1;
                                cur_slot     = p;
                                cur_valid    = 1'b1;
                                live         = live + 1'b1;
                                due_replies.push_back(reply(p, ST_OK, 1'b1, 1'b1));
                            end else begin
                                p = (p == 0) ? 5'(NSLOT - 1) : p - 1'b1;
                            end
                        end
                    end
                    if (!hit)
                        due_replies.push_back(reply('0, ST_NO_FREE, 1'b0, 1'b1));
                end
                OP_YIELD: begin
                    if (cur_valid) begin
                        cur_valid = 1'b0;
                        due_replies.push_back(reply(cur_slot, ST_MASTER, 1'b1, 1'b1));
                    end else begin
                        p = (rr_last == NSLOT - 1) ? '0 : rr_last + 1'b1;
                        for (int k = 0; k < NSLOT; k++) begin
                            if (!hit) begin
                                if (used[p] && !waiting[p]) begin
                                    hit       = 1'b1;
                                    rr_last   = p;
                                    cur_slot  = p;
                                    cur_valid = 1'b1;
                                    due_replies.push_back(reply(p, ST_OK, 1'b1, 1'b1));
                                end else begin
                                    p = (p == NSLOT - 1) ? '0 : p + 1'b1;
                                end
                            end
                        end
                        if (!hit)
                            due_replies.push_back(reply('0, ST_NONE, 1'b0, 1'b1));
                    end
                end
                OP_FINISH: begin
                    if (!cur_valid) begin
                        due_replies.push_back(reply('0, ST_UNUSED, 1'b0, 1'b1));
                    end else begin
                        if (used[cur_slot]) begin
                            used[cur_slot] = 1'b0;
                            live           = live - 1'b1;
                        end
                        cur_valid = 1'b0;
                        due_replies.push_back(reply(cur_slot, ST_OK, 1'b1, 1'b1));
                    end
                end
                OP_SUSPEND: begin
                    waiting[id] = 1'b1;
                    awaited[id] = it.event_code;
                    due_replies.push_back(reply(id, used[id] ? ST_OK : ST_UNUSED, 1'b1, 1'b1));
                end
                OP_WAKE: begin
                    for (int s = 0; s < NSLOT; s++) begin
                        if (used[s] && waiting[s] && awaited[s] == it.event_code) begin
                            waiting[s] = 1'b0;
                            woken++;
                            due_replies.push_back(reply(5'(s), ST_OK, 1'b1, 1'b0));
                        end
                    end
                    if (woken == 0)
                        due_replies.push_back(reply('0, ST_NONE, 1'b0, 1'b1));
                    else
                        due_replies[$].last = 1'b1;
                end
                OP_REQ_EXIT: begin
                    exit_flag[id] = 1'b1;
                    due_replies.push_back(reply(id, used[id] ? ST_OK : ST_UNUSED, 1'b1, 1'b1));
                end
                OP_KILL: begin
                    if (!used[id]) begin
                        due_replies.push_back(reply(id, ST_UNUSED, 1'b1, 1'b1));
                    end else begin
                        used[id] = 1'b0;
                        live     = live - 1'b1;
                        if (cur_valid && cur_slot == id)
                            cur_valid = 1'b0;
                        due_replies.push_back(reply(id, ST_OK, 1'b1, 1'b1));
                    end
                end
                default: begin
                    due_replies.push_back(reply(id, used[id] ? ST_OK : ST_UNUSED, 1'b1, 1'b1));
                end
            endcase
        endfunction

        function string show(t_out_item r);
            return $sformatf("slot=%0d status=%0d in_use=%0b exit=%0b live=%0d master=%0b last=%0b",
                             r.slot, r.status, r.in_use, r.exit_requested, r.live_count,
                             r.master_running, r.last);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            bit        bad;
            if (due_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOW)
                    $display("unexpected reply: %s", show(got));
            end else begin
                want = due_replies.pop_front();
                bad  = (got.slot !== want.slot) || (got.status !== want.status)
                    || (got.in_use !== want.in_use)
                    || (got.exit_requested !== want.exit_requested)
                    || (got.live_count !== want.live_count)
                    || (got.master_running !== want.master_running)
                    || (got.last !== want.last);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOW)
                        $display("reply mismatch: expected %s, got %s", show(want), show(got));
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, dut signals and instance
    // ------------------------------------------------------------------------
    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    sched_scoreboard sb = new();

    // idle-free stretches, one flag per side
    bit in_calm  = 1'b0;
    bit out_calm = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task_slot_round_robin_scheduler uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // drive one request transaction and note it at the accepting edge;
    // valid is only lowered when a gap follows, so back-to-back items keep it high
    task automatic issue_request(t_op op, logic [4:0] id, logic [15:0] ev);
        t_in_item it;
        int       gap;
        it.op         = op;
        it.task_id    = id;
        it.event_code = ev;
        gap = in_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(it);
    endtask

    // mostly an occupied slot, so suspend, kill and friends hit live tasks
    function automatic logic [4:0] pick_task_id();
        logic [4:0] busy[$];
        for (int s = 0; s < NSLOT; s++)
            if (sb.used[s])
                busy.push_back(5'(s));
        if (busy.size() > 0 && $urandom_range(0, 9) < 7)
            return busy[$urandom_range(0, busy.size() - 1)];
        return 5'($urandom_range(0, NSLOT - 1));
    endfunction

    // a small pool of events makes wakes hit several waiters at once
    function automatic logic [15:0] pick_event();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0005;
            3: return 16'h1234;
            4: return 16'h0005;
            5: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_op pick_op(t_phase ph);
        int r;
        r = $urandom_range(0, 99);
        case (ph)
            PH_FILL: begin
                if (r < 70) return OP_ADD;
                if (r < 78) return OP_SUSPEND;
                if (r < 84) return OP_YIELD;
                if (r < 90) return OP_WAKE;
                if (r < 95) return OP_REQ_EXIT;
                return OP_QUERY;
            end
            PH_MIX: begin
                if (r < 15) return OP_ADD;
                if (r < 35) return OP_YIELD;
                if (r < 50) return OP_SUSPEND;
                if (r < 64) return OP_WAKE;
                if (r < 72) return OP_FINISH;
                if (r < 80) return OP_KILL;
                if (r < 88) return OP_REQ_EXIT;
                return OP_QUERY;
            end
            default: begin
                if (r < 5)  return OP_ADD;
                if (r < 20) return OP_YIELD;
                if (r < 30) return OP_SUSPEND;
                if (r < 40) return OP_WAKE;
                if (r < 55) return OP_FINISH;
                if (r < 85) return OP_KILL;
                if (r < 92) return OP_REQ_EXIT;
                return OP_QUERY;
            end
        endcase
    endfunction

    task automatic random_phase(t_phase ph, int count);
        for (int k = 0; k < count; k++) begin
            // stretch with no idling at the start of the mixed phase
            in_calm  = (ph == PH_MIX) && (k < N_CALM);
            out_calm = (ph == PH_MIX) && (k < N_CALM);
            issue_request(pick_op(ph), pick_task_id(), pick_event());
        end
        in_calm  = 1'b0;
        out_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // reply side: random stall per transaction, then check
    // ------------------------------------------------------------------------
    initial begin : reply_side
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = out_calm ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_result(o_out_data);
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_ready <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table: query, master yield, finish and wake all fail
        issue_request(OP_QUERY,    5'd0,  16'h0000);
        issue_request(OP_YIELD,    5'd0,  16'h0000);
        issue_request(OP_FINISH,   5'd0,  16'h0000);
        issue_request(OP_WAKE,     5'd0,  16'h0000);
        issue_request(OP_KILL,     5'd31, 16'hFFFF);
        // wait and exit bits written on an unused slot stay until add clears them
        issue_request(OP_SUSPEND,  5'd31, 16'hFFFF);
        issue_request(OP_REQ_EXIT, 5'd31, 16'h0000);
        issue_request(OP_QUERY,    5'd31, 16'hFFFF);
        // add goes to slot 0, then the free search wraps down to 31 and 30
        issue_request(OP_ADD,      5'd0,  16'h0000);
        issue_request(OP_YIELD,    5'd0,  16'h0000);
        issue_request(OP_ADD,      5'd0,  16'h0000);
        issue_request(OP_SUSPEND,  5'd31, 16'hFFFF);
        issue_request(OP_ADD,      5'd0,  16'h0000);
        issue_request(OP_SUSPEND,  5'd30, 16'hFFFF);
        issue_request(OP_SUSPEND,  5'd0,  16'h0000);
        // task yields back to master, then master finds every slot waiting
        issue_request(OP_YIELD,    5'd0,  16'h0000);
        issue_request(OP_YIELD,    5'd0,  16'h0000);
        // wake with two waiters, then round robin picks them up
        issue_request(OP_WAKE,     5'd0,  16'hFFFF);
        issue_request(OP_YIELD,    5'd0,  16'h0000);
        issue_request(OP_REQ_EXIT, 5'd30, 16'h0000);
        issue_request(OP_QUERY,    5'd30, 16'h0000);
        // kill of the running task hands control back to master
        issue_request(OP_KILL,     5'd30, 16'h0000);
        issue_request(OP_YIELD,    5'd0,  16'h0000);
        issue_request(OP_FINISH,   5'd0,  16'h0000);
        issue_request(OP_WAKE,     5'd0,  16'h0000);

        // random traffic: fill the table, churn it, then drain it
        random_phase(PH_FILL,  N_FILL);
        random_phase(PH_MIX,   N_MIX);
        random_phase(PH_DRAIN, N_DRAIN);
        i_in_valid <= 1'b0;

        // let every predicted reply arrive, then watch for strays
        while (sb.due_replies.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.due_replies.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // hang guard, well above the slowest legal run
    initial begin : watchdog
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
